[rtl/brm_pkg.sv]
// Shared types and constants for the radix-2 Booth multiplier.
// No dependencies; every other file of the block refers to this package.
package brm_pkg;

    // Default operand width in bits.
    localparam int unsigned DEF_WIDTH = 8;

    // Control word broadcast from the sequencer to every bit cell.
    typedef struct packed {
        logic load;    // take new operands, clear the accumulator
        logic step;    // perform one Booth step and shift right
        logic add_en;  // recoded pair is 01 or 10, so the multiplicand takes part
        logic sub;     // recoded pair is 10, so the multiplicand is subtracted
    } cell_ctrl_t;

endpackage

[rtl/brm_if.sv]
// Valid/ready channel interfaces for the Booth multiplier's operands and result.
// Depends on brm_pkg for the default width.
interface brm_in_if #(
    parameter int unsigned W = brm_pkg::DEF_WIDTH
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] multiplicand;
    logic signed [W-1:0] multiplier;

    modport source (output valid, output multiplicand, output multiplier, input ready);
    modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface brm_out_if #(
    parameter int unsigned W = brm_pkg::DEF_WIDTH
);
    logic                  valid;
    logic                  ready;
    logic signed [2*W-1:0] product;

    modport source (output valid, output product, input ready);
    modport sink   (input valid, input product, output ready);
endinterface

[rtl/brm_cell.sv]
// One bit slice of the Booth multiplier: accumulator, multiplier and multiplicand bits
// with a full adder. Depends on brm_pkg for the control word type.
module brm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  brm_pkg::cell_ctrl_t ctrl,
    input  logic               load_mcand,
    input  logic               load_mult,
    input  logic               carry_in,
    input  logic               acc_shift_in,
    input  logic               mult_shift_in,
    output logic               carry_out,
    output logic               sum,
    output logic               mult_bit
);

    logic acc_reg;
    logic mult_reg;
    logic mcand_reg;
    logic addend;

    // Subtraction is addition of the inverted multiplicand with a carry into bit 0.
    assign addend    = ctrl.add_en & (mcand_reg ^ ctrl.sub);
    assign sum       = acc_reg ^ addend ^ carry_in;
    assign carry_out = (acc_reg & addend) | (carry_in & (acc_reg ^ addend));
    assign mult_bit  = mult_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= 1'b0;
            mult_reg  <= 1'b0;
            mcand_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            acc_reg   <= 1'b0;
            mult_reg  <= load_mult;
            mcand_reg <= load_mcand;
        end
        else if (ctrl.step)
        begin
            acc_reg  <= acc_shift_in;
            mult_reg <= mult_shift_in;
        end
    end

endmodule

[rtl/booth_radix2_multiplier_top.sv]
// Radix-2 Booth multiplier, a row of WIDTH bit cells driven by a step sequencer.
// New operands are taken only after the single row of cells has loaded the last pair
// and performed its WIDTH Booth steps one after another; the final step also waits
// until the output register can take the new product.
// Reset: rst_n is asynchronous and active low; it clears the cells, the sequencer
// and the output register, so no result is pending after reset.
module booth_radix2_multiplier_top #(
    parameter int unsigned WIDTH = brm_pkg::DEF_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    brm_in_if.sink    operands,
    brm_out_if.source result
);

    // Narrowest counter that can index the WIDTH steps of one multiplication.
    localparam int unsigned CNT_W = (WIDTH > 2) ? $clog2(WIDTH) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);

    logic                      busy_reg;
    logic                      busy_next;
    logic [CNT_W-1:0]          step_count_reg;
    logic [CNT_W-1:0]          step_count_next;
    logic                      prev_bit_reg;
    logic                      prev_bit_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [2*WIDTH-1:0] product_reg;
    logic signed [2*WIDTH-1:0] product_next;

    logic                      accept;
    logic                      out_free;
    logic                      last_step;
    logic                      finish;
    brm_pkg::cell_ctrl_t       ctrl;

    logic [WIDTH:0]            carry;
    logic [WIDTH-1:0]          sum_vec;
    logic [WIDTH-1:0]          mult_vec;
    logic [WIDTH-1:0]          acc_shift;
    logic [WIDTH-1:0]          mult_shift;

    // The block takes a new transaction only when the row of cells is free. A result
    // still waiting in the output register does not hold up the next multiplication;
    // only the final step waits until the output register can take the new product.
    assign operands.ready = !busy_reg;
    assign accept         = operands.valid && !busy_reg;
    assign out_free       = !out_valid_reg || result.ready;
    assign last_step      = (step_count_reg == LAST_STEP);
    assign finish         = busy_reg && last_step && out_free;

    // Booth recoding of the multiplier's low bit and the bit shifted out before it:
    // 10 subtracts the multiplicand, 01 adds it, 00 and 11 leave the accumulator alone.
    always_comb
    begin
        ctrl.load   = accept;
        ctrl.step   = busy_reg && (!last_step || out_free);
        ctrl.add_en = mult_vec[0] ^ prev_bit_reg;
        ctrl.sub    = mult_vec[0] & !prev_bit_reg;
    end

    assign carry[0] = ctrl.sub;

    // Each cell receives, for the right shift, the new accumulator bit from its left
    // neighbour. The top cell repeats its own sum bit (arithmetic shift), and the
    // multiplier's top bit takes the sum bit leaving the accumulator's bottom.
    always_comb
    begin
        acc_shift  = {sum_vec[WIDTH-1], sum_vec[WIDTH-1:1]};
        mult_shift = {sum_vec[0], mult_vec[WIDTH-1:1]};
    end

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_cell
        brm_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .load_mcand    (operands.multiplicand[i]),
            .load_mult     (operands.multiplier[i]),
            .carry_in      (carry[i]),
            .acc_shift_in  (acc_shift[i]),
            .mult_shift_in (mult_shift[i]),
            .carry_out     (carry[i+1]),
            .sum           (sum_vec[i]),
            .mult_bit      (mult_vec[i])
        );
    end

    // Sequencer and output register.
    always_comb
    begin
        busy_next       = busy_reg;
        step_count_next = step_count_reg;
        prev_bit_next   = prev_bit_reg;
        out_valid_next  = out_valid_reg;
        product_next    = product_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            busy_next       = 1'b1;
            step_count_next = '0;
            prev_bit_next   = 1'b0;
        end
        else if (ctrl.step)
        begin
            prev_bit_next   = mult_vec[0];
            step_count_next = step_count_reg + 1'b1;
        end

        // The final step's shifted pair is captured straight into the output register.
        if (finish)
        begin
            busy_next       = 1'b0;
            step_count_next = '0;
            out_valid_next  = 1'b1;
            product_next    = {acc_shift, mult_shift};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            step_count_reg <= '0;
            prev_bit_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            product_reg    <= '0;
        end
        else
        begin
            busy_reg       <= busy_next;
            step_count_reg <= step_count_next;
            prev_bit_reg   <= prev_bit_next;
            out_valid_reg  <= out_valid_next;
            product_reg    <= product_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.product = product_reg;

endmodule

[rtl/brm_checker.sv]
// Port-level assertions for the Booth multiplier, bound to the top level.
// Depends on booth_radix2_multiplier_top and the brm channel interfaces.
module brm_checker #(
    parameter int unsigned WIDTH = brm_pkg::DEF_WIDTH
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [2*WIDTH-1:0] product
);

    // A transaction occupies the cells, so the next one cannot follow directly.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("operand channel ready straight after a transaction");

    // The cells stay busy through all WIDTH steps.
    a_busy_for_all_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##WIDTH !in_ready)
        else $error("operand channel ready before all steps were done");

    // A new result appears only as the cells become free.
    a_result_frees_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result appeared while the cells were still busy");

    a_product_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(product)))
        else $error("stalled product changed or was dropped");

endmodule

bind booth_radix2_multiplier_top brm_checker #(.WIDTH(WIDTH)) u_brm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .product   (result.product)
);
